FILE: rtl/sal_pkg.sv
package sal_pkg;

  localparam int unsigned LIST_DEPTH_DEFAULT = 128;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    RES_INSERT = 3'd0,
    RES_HIT    = 3'd1,
    RES_FULL   = 3'd2,
    RES_MISS   = 3'd3,
    RES_NOP    = 3'd4
  } res_e;

  typedef struct packed {
    logic load_op;
    logic rd_fh;
    logic alloc;
    logic rd_cur;
    logic advance;
    logic link_new;
    logic link_prev;
    logic hold_next;
    logic unlink;
    logic free;
    logic load_res;
    res_e res_kind;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  fh_null;
    logic  cur_null;
    logic  val_lt;
    logic  val_eq;
    logic  out_free;
  } sts_t;

endpackage

FILE: rtl/sal_dp.sv
module sal_dp #(
  parameter int unsigned LIST_DEPTH = sal_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  sal_pkg::cmd_t      cmd_i,
  output sal_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [6:0]         position_o,
  output logic [7:0]         count_o
);

  localparam int unsigned IW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam logic [IW-1:0] NULL_IDX = IW'(LIST_DEPTH);

  logic [31:0]        mem_val [LIST_DEPTH];
  logic [IW-1:0]      mem_nxt [LIST_DEPTH];

  logic [1:0]         mode_q;
  logic signed [31:0] v_q;
  logic [IW-1:0]      cur_q, prev_q, s_q, nh_q;
  logic [IW-1:0]      fh_q, hw_q, head_q, cnt_q;
  logic signed [31:0] rd_val_q;
  logic [IW-1:0]      rd_nxt_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [6:0]         position_q;
  logic [7:0]         count_q;

  logic [IW-1:0]      rd_addr;
  logic               rd_en;
  logic               prev_null;
  logic               nxt_we;
  logic [IW-1:0]      nxt_waddr, nxt_wdata;

  assign prev_null = (prev_q >= NULL_IDX);
  assign rd_addr   = cmd_i.rd_fh ? fh_q : (cmd_i.advance ? rd_nxt_q : cur_q);
  assign rd_en     = (cmd_i.rd_fh | cmd_i.rd_cur | cmd_i.advance) && (rd_addr < NULL_IDX);

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = s_q;
    nxt_wdata = cur_q;
    if (cmd_i.link_new) begin
      nxt_we = 1'b1;
    end else if (cmd_i.link_prev && !prev_null) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_q;
      nxt_wdata = s_q;
    end else if (cmd_i.unlink && !prev_null) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_q;
      nxt_wdata = nh_q;
    end else if (cmd_i.free) begin
      nxt_we    = 1'b1;
      nxt_waddr = cur_q;
      nxt_wdata = fh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      mem_val[fh_q[AW-1:0]] <= v_q;
    end
    if (nxt_we) begin
      mem_nxt[nxt_waddr[AW-1:0]] <= nxt_wdata;
    end
    if (rd_en) begin
      rd_val_q <= mem_val[rd_addr[AW-1:0]];
      rd_nxt_q <= mem_nxt[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      mode_q <= mode_i;
      v_q    <= value_i;
      cur_q  <= head_q;
      prev_q <= NULL_IDX;
    end else if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= rd_nxt_q;
    end
    if (cmd_i.alloc) begin
      s_q <= fh_q;
    end
    if (cmd_i.hold_next) begin
      nh_q <= rd_nxt_q;
    end
  end

  // Slots at or above the high-water mark have never been taken; their link is the next slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q   <= '0;
      hw_q   <= '0;
      head_q <= NULL_IDX;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.alloc) begin
        if (fh_q == hw_q) begin
          fh_q <= hw_q + IW'(1);
          hw_q <= hw_q + IW'(1);
        end else begin
          fh_q <= rd_nxt_q;
        end
      end
      if (cmd_i.link_prev) begin
        if (prev_null) begin
          head_q <= s_q;
        end
        cnt_q <= cnt_q + IW'(1);
      end
      if (cmd_i.unlink && prev_null) begin
        head_q <= nh_q;
      end
      if (cmd_i.free) begin
        fh_q  <= cur_q;
        cnt_q <= cnt_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      count_q <= 8'(cnt_q);
      case (cmd_i.res_kind)
        sal_pkg::RES_INSERT: begin
          status_q   <= sal_pkg::STATUS_OK;
          position_q <= 7'(s_q);
        end
        sal_pkg::RES_HIT: begin
          status_q   <= sal_pkg::STATUS_OK;
          position_q <= 7'(cur_q);
        end
        sal_pkg::RES_FULL: begin
          status_q   <= sal_pkg::STATUS_FULL;
          position_q <= '0;
        end
        sal_pkg::RES_MISS: begin
          status_q   <= sal_pkg::STATUS_MISS;
          position_q <= '0;
        end
        default: begin
          status_q   <= sal_pkg::STATUS_OK;
          position_q <= '0;
        end
      endcase
    end
  end

  assign sts_o.mode     = sal_pkg::mode_e'(mode_q);
  assign sts_o.fh_null  = (fh_q >= NULL_IDX);
  assign sts_o.cur_null = (cur_q >= NULL_IDX);
  assign sts_o.val_lt   = (rd_val_q < v_q);
  assign sts_o.val_eq   = (rd_val_q == v_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = position_q;
  assign count_o     = count_q;

endmodule

FILE: rtl/sal_ctrl.sv
module sal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sal_pkg::sts_t sts_i,
  output sal_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_DISPATCH   = 11'b000_0000_0010,
    ST_ALLOC_RD   = 11'b000_0000_0100,
    ST_ALLOC_WR   = 11'b000_0000_1000,
    ST_WALK_START = 11'b000_0001_0000,
    ST_WALK       = 11'b000_0010_0000,
    ST_LINK_NEW   = 11'b000_0100_0000,
    ST_LINK_PREV  = 11'b000_1000_0000,
    ST_UNLINK     = 11'b001_0000_0000,
    ST_FREE       = 11'b010_0000_0000,
    ST_DONE       = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  sal_pkg::res_e res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_kind = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.mode)
          sal_pkg::MODE_INSERT: begin
            if (sts_i.fh_null) begin
              res_d   = sal_pkg::RES_FULL;
              state_d = ST_DONE;
            end else begin
              state_d = ST_ALLOC_RD;
            end
          end
          sal_pkg::MODE_SEARCH, sal_pkg::MODE_DELETE: begin
            state_d = ST_WALK_START;
          end
          default: begin
            res_d   = sal_pkg::RES_NOP;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_ALLOC_RD: begin
        cmd_o.rd_fh = 1'b1;
        state_d = ST_ALLOC_WR;
      end
      ST_ALLOC_WR: begin
        cmd_o.alloc = 1'b1;
        state_d = ST_WALK_START;
      end
      ST_WALK_START: begin
        cmd_o.rd_cur = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.cur_null) begin
          if (sts_i.mode == sal_pkg::MODE_INSERT) begin
            state_d = ST_LINK_NEW;
          end else begin
            res_d   = sal_pkg::RES_MISS;
            state_d = ST_DONE;
          end
        end else if (sts_i.mode == sal_pkg::MODE_INSERT) begin
          if (sts_i.val_lt) begin
            cmd_o.advance = 1'b1;
          end else begin
            state_d = ST_LINK_NEW;
          end
        end else if (sts_i.val_eq) begin
          res_d = sal_pkg::RES_HIT;
          if (sts_i.mode == sal_pkg::MODE_DELETE) begin
            cmd_o.hold_next = 1'b1;
            state_d = ST_UNLINK;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_LINK_NEW: begin
        cmd_o.link_new = 1'b1;
        state_d = ST_LINK_PREV;
      end
      ST_LINK_PREV: begin
        cmd_o.link_prev = 1'b1;
        res_d   = sal_pkg::RES_INSERT;
        state_d = ST_DONE;
      end
      ST_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = ST_FREE;
      end
      ST_FREE: begin
        cmd_o.free = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= sal_pkg::RES_NOP;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: rtl/sorted_array_linked_list.sv
// Sorted linked list of signed 32-bit values in a pool of LIST_DEPTH slots. Each input
// transfer carries a mode (insert, search, delete, or a no-operation code) and a value, and
// yields exactly one result transfer with status, slot position and the stored count. One
// operation is handled at a time. The walk steps past at most the stored count of entries,
// and an insert into a full list and the no-operation code do not walk at all. The walk advances
// one entry per cycle through the registered read port of the slot memories. The next input
// transfer can be taken in the same cycle that the result is offered; a result that is still
// waiting holds the following operation in its last cycle until the output frees. No clearing
// pass is needed after reset: untouched slots are tracked by a high-water mark, so the block
// is ready as soon as reset ends.
module sorted_array_linked_list #(
  parameter int unsigned LIST_DEPTH = sal_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [6:0]         position_o,
  output logic [7:0]         count_o
);

  sal_pkg::cmd_t cmd;
  sal_pkg::sts_t sts;

  sal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sal_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .count_o     (count_o)
  );

endmodule

FILE: rtl/sal_checker.sv
module sal_checker #(
  parameter int unsigned LIST_DEPTH = sal_pkg::LIST_DEPTH_DEFAULT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [6:0]         position_o,
  input logic [7:0]         count_o
);

  // A result that waits keeps its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(position_o) && $stable(count_o))
    else $error("result changed while stalled");

  // The block takes no new transfer in the cycle after accepting one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A failed operation reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != sal_pkg::STATUS_OK) |-> position_o == 7'd0)
    else $error("non-zero position on failure");

  // A full report comes only when every slot holds a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sal_pkg::STATUS_FULL) |-> count_o == 8'(LIST_DEPTH))
    else $error("full reported with free slots");

endmodule

bind sorted_array_linked_list sal_checker #(.LIST_DEPTH(LIST_DEPTH)) u_sal_checker (.*);
